// ----- rtl/core/isotp_pkg.sv -----
// Shared types and constants of the ISO-TP frame receiver.
package isotp_pkg;

  localparam int FRAME_BYTES = 8;
  localparam int HEADER_LEN  = 3;
  localparam int CF_BYTES    = 7;
  localparam int MAX_RESULTS = HEADER_LEN + CF_BYTES;

  localparam logic [28:0] FC_OFFSET     = 29'h8;
  localparam logic [3:0]  FC_LEN_PADDED = 4'd8;
  localparam logic [3:0]  FC_LEN_SHORT  = 4'd1;
  localparam logic [3:0]  FF_BYTES      = 4'(FRAME_BYTES - 2);

  typedef enum logic [3:0] {
    PCI_SF     = 4'd0,
    PCI_FIRST  = 4'd1,
    PCI_CONSEC = 4'd2
  } pci_e;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_BYTE = 2'd1,
    KIND_FC   = 2'd2,
    KIND_ERR  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    CFG_RX_ID    = 2'd0,
    CFG_PAD      = 2'd1,
    CFG_MAX_SIZE = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [28:0] frame_id;
    logic [3:0]  frame_len;
    logic [7:0]  byte0;
    logic [7:0]  byte1;
    logic [7:0]  byte2;
    logic [7:0]  byte3;
    logic [7:0]  byte4;
    logic [7:0]  byte5;
    logic [7:0]  byte6;
    logic [7:0]  byte7;
  } frame_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  byte_value;
    logic        last;
    logic [3:0]  message_size;
    logic        done_res;
    logic        segmented;
    logic [28:0] fc_id;
    logic [3:0]  fc_length;
  } result_t;

  typedef struct packed {
    logic [3:0]                        count;
    kind_e                             first_kind;
    logic [MAX_RESULTS-1:0][7:0]       data;
    logic [3:0]                        message_size;
    logic                              done_res;
    logic                              segmented;
    logic [28:0]                       fc_id;
    logic [3:0]                        fc_length;
  } burst_t;

endpackage

// ----- rtl/core/isotp_frame_if.sv -----
// Valid/ready channel carrying one CAN frame per beat.
interface isotp_frame_if;
  logic               valid;
  logic               ready;
  isotp_pkg::frame_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/core/isotp_result_if.sv -----
// Valid/ready channel carrying one receive result per beat.
interface isotp_result_if;
  logic               valid;
  logic               ready;
  isotp_pkg::result_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/core/isotp_frame_receiver.sv -----
// Top level of the ISO-TP receive block for one configured receive id.
//
// Usage:
//   frame_i carries one CAN frame per beat (id, length, eight data bytes).
//   result_o carries the results of each frame, one per beat, with last set
//   on the final result of that frame. A frame that is ignored (zero length,
//   foreign id, unknown PCI, oversized first frame) gives no results.
//   cfg_we_i/cfg_idx_i/cfg_data_i write rx_id (0), pad_frames (1) and
//   max_message_size (2) while the block is idle.
// Path: a frame passes the input register, then the burst register, then
//   the output register, from which result_o is driven.
// Throughput: one result per cycle out of the burst register while result_o is
//   not stalled, so a frame gives 1 to 10 results; an ignored frame is dropped
//   from the input register without reaching the burst register. The next frame
//   is decoded while the previous burst drains.
// Reset: clears all valids, the received and expected counts, and loads the
//   configuration defaults (rx_id 0, padding on, limit 4095).
// Stall: when result_o.ready is low the output beat holds, the burst waits,
//   and frame_i.ready drops once the input register is also full.
module isotp_frame_receiver (
  input  logic            clk_i,
  input  logic            rst_ni,
  isotp_frame_if.sink     frame_i,
  isotp_result_if.source  result_o,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_idx_i,
  input  logic [28:0]     cfg_data_i
);

  logic               burst_valid;
  logic               burst_ready;
  isotp_pkg::burst_t  burst;

  isotp_rx_decode u_decode (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .frame_i       (frame_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .burst_ready_i (burst_ready),
    .burst_valid_o (burst_valid),
    .burst_o       (burst)
  );

  isotp_rx_serial u_serial (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .burst_valid_i (burst_valid),
    .burst_i       (burst),
    .burst_ready_o (burst_ready),
    .result_o      (result_o)
  );

endmodule

// ----- rtl/core/isotp_rx_decode.sv -----
// Frame input register, PCI decode, reassembly state and configuration registers.
module isotp_rx_decode (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  isotp_frame_if.sink           frame_i,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_idx_i,
  input  logic [28:0]           cfg_data_i,
  input  logic                  burst_ready_i,
  output logic                  burst_valid_o,
  output isotp_pkg::burst_t     burst_o
);

  logic                  s1_valid_q;
  isotp_pkg::frame_t     frame_q;
  logic [28:0]           rx_id_q;
  logic                  pad_q;
  logic [11:0]           max_size_q;
  logic [11:0]           rcv_q, rcv_d;
  logic [11:0]           exp_q, exp_d;
  logic [isotp_pkg::HEADER_LEN-1:0][7:0] hdr_q, hdr_d;
  logic [isotp_pkg::FRAME_BYTES-1:0][7:0] d;
  logic                  hit;
  logic                  drop;
  logic                  adv;
  logic [2:0]            plen;
  logic [11:0]           total;
  logic [11:0]           rem;
  logic [11:0]           new_rcv;
  isotp_pkg::burst_t     burst;

  assign d = {frame_q.byte7, frame_q.byte6, frame_q.byte5, frame_q.byte4,
              frame_q.byte3, frame_q.byte2, frame_q.byte1, frame_q.byte0};

  assign hit     = (frame_q.frame_len != 4'd0) && (frame_q.frame_id == rx_id_q);
  assign plen    = (d[0][3:0] > 4'd7) ? 3'd7 : d[0][2:0];
  assign total   = {d[0][3:0], d[1]};
  assign rem     = exp_q - rcv_q;
  assign new_rcv = rcv_q + rem;

  always_comb begin
    burst = '0;
    burst.first_kind = isotp_pkg::KIND_BYTE;
    drop  = 1'b1;
    hdr_d = hdr_q;
    rcv_d = rcv_q;
    exp_d = exp_q;
    if (hit) begin
      case (d[0][7:4])
        isotp_pkg::PCI_SF: begin
          drop = 1'b0;
          burst.done_res = 1'b1;
          if (plen == 3'd0) begin
            burst.count      = 4'd1;
            burst.first_kind = isotp_pkg::KIND_NONE;
          end else begin
            burst.count        = {1'b0, plen};
            burst.message_size = {1'b0, plen};
            for (int i = 0; i < isotp_pkg::CF_BYTES; i++) begin
              burst.data[i] = d[i+1];
            end
          end
        end
        isotp_pkg::PCI_FIRST: begin
          if (total <= max_size_q) begin
            drop = 1'b0;
            burst.count        = 4'(1 + isotp_pkg::FRAME_BYTES - 2);
            burst.first_kind   = isotp_pkg::KIND_FC;
            burst.message_size = isotp_pkg::FF_BYTES;
            burst.segmented    = 1'b1;
            burst.fc_id        = frame_q.frame_id - isotp_pkg::FC_OFFSET;
            burst.fc_length    = pad_q ? isotp_pkg::FC_LEN_PADDED : isotp_pkg::FC_LEN_SHORT;
            for (int i = 2; i < isotp_pkg::FRAME_BYTES; i++) begin
              burst.data[i-1] = d[i];
            end
            for (int i = 0; i < isotp_pkg::HEADER_LEN; i++) begin
              hdr_d[i] = d[i+2];
            end
            rcv_d = 12'(isotp_pkg::FF_BYTES);
            exp_d = total;
          end
        end
        isotp_pkg::PCI_CONSEC: begin
          drop = 1'b0;
          burst.segmented = 1'b1;
          if (rem > 12'(isotp_pkg::CF_BYTES)) begin
            burst.count        = 4'(isotp_pkg::CF_BYTES);
            burst.message_size = 4'(isotp_pkg::CF_BYTES);
            for (int i = 0; i < isotp_pkg::CF_BYTES; i++) begin
              burst.data[i] = d[i+1];
            end
            rcv_d = rcv_q + 12'(isotp_pkg::CF_BYTES);
          end else begin
            rcv_d = new_rcv;
            if (new_rcv != exp_q) begin
              burst.count      = 4'd1;
              burst.first_kind = isotp_pkg::KIND_ERR;
            end else begin
              burst.count        = 4'(rem[2:0]) + 4'(isotp_pkg::HEADER_LEN);
              burst.message_size = 4'(rem[2:0]) + 4'(isotp_pkg::HEADER_LEN);
              burst.done_res     = 1'b1;
              for (int i = 0; i < isotp_pkg::HEADER_LEN; i++) begin
                burst.data[i] = hdr_q[i];
              end
              for (int i = 0; i < isotp_pkg::CF_BYTES; i++) begin
                burst.data[isotp_pkg::HEADER_LEN+i] = d[i+1];
              end
            end
          end
        end
        default: begin
          drop = 1'b1;
        end
      endcase
    end
  end

  assign adv           = s1_valid_q && (drop || burst_ready_i);
  assign frame_i.ready = !s1_valid_q || adv;
  assign burst_valid_o = s1_valid_q && !drop;
  assign burst_o       = burst;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (frame_i.ready) begin
      s1_valid_q <= frame_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_i.ready && frame_i.valid) begin
      frame_q <= frame_i.payload;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && !drop) begin
      hdr_q <= hdr_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rcv_q <= '0;
      exp_q <= '0;
    end else if (adv && !drop) begin
      rcv_q <= rcv_d;
      exp_q <= exp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_id_q    <= '0;
      pad_q      <= 1'b1;
      max_size_q <= 12'hFFF;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        isotp_pkg::CFG_RX_ID:    rx_id_q    <= cfg_data_i;
        isotp_pkg::CFG_PAD:      pad_q      <= cfg_data_i[0];
        isotp_pkg::CFG_MAX_SIZE: max_size_q <= cfg_data_i[11:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/isotp_rx_serial.sv -----
// Burst register that hands out one result per beat into the output register.
module isotp_rx_serial (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  burst_valid_i,
  input  isotp_pkg::burst_t     burst_i,
  output logic                  burst_ready_o,
  isotp_result_if.source        result_o
);

  logic                  busy_q;
  logic                  first_q;
  isotp_pkg::burst_t     burst_q;
  logic                  out_valid_q;
  isotp_pkg::result_t    out_q;
  isotp_pkg::result_t    head;
  logic                  emit;
  logic                  final_beat;

  always_comb begin
    head              = '0;
    head.kind         = first_q ? burst_q.first_kind : isotp_pkg::KIND_BYTE;
    head.byte_value   = burst_q.data[0];
    head.last         = (burst_q.count == 4'd1);
    head.message_size = burst_q.message_size;
    head.done_res     = burst_q.done_res;
    head.segmented    = burst_q.segmented;
    if (first_q && burst_q.first_kind == isotp_pkg::KIND_FC) begin
      head.fc_id     = burst_q.fc_id;
      head.fc_length = burst_q.fc_length;
    end
  end

  assign emit          = busy_q && (!out_valid_q || result_o.ready);
  assign final_beat    = emit && (burst_q.count == 4'd1);
  assign burst_ready_o = !busy_q || final_beat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      first_q <= 1'b0;
    end else if (burst_ready_o) begin
      busy_q  <= burst_valid_i;
      first_q <= 1'b1;
    end else if (emit) begin
      first_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (burst_ready_o && burst_valid_i) begin
      burst_q <= burst_i;
    end else if (emit) begin
      burst_q.count <= burst_q.count - 4'd1;
      burst_q.data  <= {8'h00, burst_q.data[isotp_pkg::MAX_RESULTS-1:1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= head;
    end
  end

  assign result_o.valid   = out_valid_q;
  assign result_o.payload = out_q;

endmodule

// ----- rtl/core/isotp_rx_checker.sv -----
// Port-level assertions for the ISO-TP frame receiver and their bind.
module isotp_rx_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  out_kind_i,
  input logic [7:0]  out_byte_i,
  input logic        out_last_i,
  input logic [28:0] out_fc_id_i,
  input logic [3:0]  out_fc_length_i
);

  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("result valid during reset");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_kind_i) && $stable(out_byte_i)
      && $stable(out_last_i))
    else $error("stalled result changed");

  a_fc_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_kind_i != isotp_pkg::KIND_FC |->
      out_fc_id_i == '0 && out_fc_length_i == '0)
    else $error("flow control fields on non flow control result");

  a_fc_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_kind_i == isotp_pkg::KIND_FC |->
      !out_last_i && (out_fc_length_i == isotp_pkg::FC_LEN_PADDED
                      || out_fc_length_i == isotp_pkg::FC_LEN_SHORT))
    else $error("malformed flow control request");

  a_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_kind_i != isotp_pkg::KIND_BYTE |-> out_byte_i == 8'h00)
    else $error("byte value on non payload result");

endmodule

bind isotp_frame_receiver isotp_rx_checker u_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (result_o.valid),
  .out_ready_i     (result_o.ready),
  .out_kind_i      (result_o.payload.kind),
  .out_byte_i      (result_o.payload.byte_value),
  .out_last_i      (result_o.payload.last),
  .out_fc_id_i     (result_o.payload.fc_id),
  .out_fc_length_i (result_o.payload.fc_length)
);

// ----- sim/isotp_frame_receiver_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench of the ISO-TP frame receiver with directed and random frames.
module isotp_frame_receiver_tb;

  localparam logic [3:0] PCI_FLOW = 4'd3;
  localparam logic [3:0] PCI_MAX  = 4'hF;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_FRAMES  = 36;
  localparam int DRAIN_LIMIT   = 20000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [28:0] cfg_data;

  isotp_frame_if  frame_ch ();
  isotp_result_if result_ch ();

  isotp_frame_receiver dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .frame_i   (frame_ch),
    .result_o  (result_ch),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  logic [28:0]          m_rx_id;
  logic                 m_pad;
  logic [11:0]          m_max_size;
  logic [7:0]           m_header [isotp_pkg::HEADER_LEN];
  logic [11:0]          m_rcv_count;
  logic [11:0]          m_total;
  isotp_pkg::result_t   expected_q [$];
  isotp_pkg::result_t   want;

  int errors = 0;
  int frames_sent = 0;
  int busy_frames = 0;
  int results_seen = 0;
  int completions = 0;
  int phases = 0;
  int burst_left = 4;
  int rdy_mode = 0;
  int mode_left = 0;
  logic [7:0] rdy_tick = 8'd0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic isotp_pkg::result_t make_result(isotp_pkg::kind_e kind, logic [7:0] value,
                                                     logic [3:0] size, logic done, logic multi,
                                                     logic [28:0] fcid, logic [3:0] fclen);
    isotp_pkg::result_t r;
    r.kind         = kind;
    r.byte_value   = value;
    r.last         = 1'b0;
    r.message_size = size;
    r.done_res     = done;
    r.segmented    = multi;
    r.fc_id        = fcid;
    r.fc_length    = fclen;
    return r;
  endfunction

  function automatic int predict_frame(isotp_pkg::frame_t f);
    logic [7:0]         d [isotp_pkg::FRAME_BYTES];
    logic [3:0]         plen;
    logic [11:0]        total;
    logic [11:0]        remaining;
    isotp_pkg::result_t tail;
    int                 n;
    n = expected_q.size();
    d = '{f.byte0, f.byte1, f.byte2, f.byte3, f.byte4, f.byte5, f.byte6, f.byte7};
    if (f.frame_len == 4'd0 || f.frame_id != m_rx_id) return 0;
    case (d[0][7:4])
      isotp_pkg::PCI_SF: begin
        plen = (d[0][3:0] > 4'd7) ? 4'd7 : d[0][3:0];
        if (plen == 4'd0) begin
          expected_q.push_back(make_result(isotp_pkg::KIND_NONE, 8'd0, 4'd0, 1'b1, 1'b0,
                                           29'd0, 4'd0));
        end else begin
          for (int i = 0; i < plen; i++)
            expected_q.push_back(make_result(isotp_pkg::KIND_BYTE, d[1+i], plen, 1'b1, 1'b0,
                                             29'd0, 4'd0));
        end
      end
      isotp_pkg::PCI_FIRST: begin
        total = {d[0][3:0], d[1]};
        if (total > m_max_size) return 0;
        for (int i = 0; i < isotp_pkg::HEADER_LEN; i++) m_header[i] = d[2+i];
        m_rcv_count = 12'(isotp_pkg::FRAME_BYTES - 2);
        m_total     = total;
        expected_q.push_back(make_result(isotp_pkg::KIND_FC, 8'd0, isotp_pkg::FF_BYTES,
                                         1'b0, 1'b1, f.frame_id - isotp_pkg::FC_OFFSET,
                                         m_pad ? isotp_pkg::FC_LEN_PADDED
                                               : isotp_pkg::FC_LEN_SHORT));
        for (int i = 2; i < isotp_pkg::FRAME_BYTES; i++)
          expected_q.push_back(make_result(isotp_pkg::KIND_BYTE, d[i], isotp_pkg::FF_BYTES,
                                           1'b0, 1'b1, 29'd0, 4'd0));
      end
      isotp_pkg::PCI_CONSEC: begin
        remaining = m_total - m_rcv_count;
        if (remaining > 12'(isotp_pkg::CF_BYTES)) begin
          m_rcv_count = m_rcv_count + 12'(isotp_pkg::CF_BYTES);
          for (int i = 1; i <= isotp_pkg::CF_BYTES; i++)
            expected_q.push_back(make_result(isotp_pkg::KIND_BYTE, d[i],
                                             4'(isotp_pkg::CF_BYTES), 1'b0, 1'b1,
                                             29'd0, 4'd0));
        end else begin
          m_rcv_count = m_rcv_count + remaining;
          if (m_rcv_count != m_total) begin
            expected_q.push_back(make_result(isotp_pkg::KIND_ERR, 8'd0, 4'd0, 1'b0, 1'b1,
                                             29'd0, 4'd0));
          end else begin
            for (int i = 0; i < isotp_pkg::HEADER_LEN; i++)
              expected_q.push_back(make_result(isotp_pkg::KIND_BYTE, m_header[i],
                                               4'(remaining + isotp_pkg::HEADER_LEN),
                                               1'b1, 1'b1, 29'd0, 4'd0));
            for (int i = 0; i < remaining; i++)
              expected_q.push_back(make_result(isotp_pkg::KIND_BYTE, d[1+i],
                                               4'(remaining + isotp_pkg::HEADER_LEN),
                                               1'b1, 1'b1, 29'd0, 4'd0));
            completions++;
          end
        end
      end
      default: return 0;
    endcase
    tail = expected_q.pop_back();
    tail.last = 1'b1;
    expected_q.push_back(tail);
    return expected_q.size() - n;
  endfunction

  function automatic isotp_pkg::frame_t make_frame(logic [28:0] id, logic [3:0] len,
                                                   logic [7:0] b0);
    isotp_pkg::frame_t f;
    f.frame_id  = id;
    f.frame_len = len;
    f.byte0     = b0;
    f.byte1     = 8'($urandom);
    f.byte2     = 8'($urandom);
    f.byte3     = 8'($urandom);
    f.byte4     = 8'($urandom);
    f.byte5     = 8'($urandom);
    f.byte6     = 8'($urandom);
    f.byte7     = 8'($urandom);
    return f;
  endfunction

  function automatic isotp_pkg::frame_t noise_frame();
    isotp_pkg::frame_t f;
    logic [3:0]        len;
    len = 4'($urandom_range(1, 8));
    case ($urandom_range(0, 3))
      0: f = make_frame(m_rx_id, 4'd0, 8'($urandom));
      1: f = make_frame(m_rx_id ^ 29'($urandom_range(1, 29'h1FFFFFFF)), len, 8'($urandom));
      2: f = make_frame(m_rx_id, len, {4'($urandom_range(PCI_FLOW, PCI_MAX)), 4'($urandom)});
      default: f = make_frame(m_rx_id, len, {isotp_pkg::PCI_SF, 4'($urandom)});
    endcase
    return f;
  endfunction

  task automatic send_frame(isotp_pkg::frame_t f);
    frame_ch.payload <= f;
    frame_ch.valid   <= 1'b1;
    do @(posedge clk); while (!frame_ch.ready);
    frames_sent++;
    if (predict_frame(f) > 0) busy_frames++;
    burst_left--;
    if (burst_left <= 0) begin
      frame_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
    end
  endtask

  task automatic wait_idle();
    frame_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_config(logic [28:0] rx, logic pad, logic [11:0] max_size);
    wait_idle();
    cfg_we   <= 1'b1;
    cfg_idx  <= isotp_pkg::CFG_RX_ID;
    cfg_data <= rx;
    @(posedge clk);
    cfg_idx  <= isotp_pkg::CFG_PAD;
    cfg_data <= 29'(pad);
    @(posedge clk);
    cfg_idx  <= isotp_pkg::CFG_MAX_SIZE;
    cfg_data <= 29'(max_size);
    @(posedge clk);
    cfg_we   <= 1'b0;
    m_rx_id    = rx;
    m_pad      = pad;
    m_max_size = max_size;
    phases++;
  endtask

  task automatic check_field(string name, logic [31:0] expv, logic [31:0] actv);
    if (expv !== actv) begin
      errors++;
      $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, name, expv, actv);
    end
  endtask

  always @(posedge clk) begin
    if (mode_left == 0) begin
      rdy_mode  <= $urandom_range(0, 3);
      mode_left <= $urandom_range(40, 300);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (rdy_mode)
      0: result_ch.ready <= 1'b1;
      1: result_ch.ready <= ($urandom_range(0, 3) != 0);
      2: result_ch.ready <= (rdy_tick[2:0] < 3'd3);
      default: result_ch.ready <= ($urandom_range(0, 7) == 0);
    endcase
    rdy_tick <= rdy_tick + 8'd1;
  end

  always @(posedge clk) begin
    if (rst_n && result_ch.valid && result_ch.ready) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing expected, actual 0x%0h", $time,
                 result_ch.payload);
      end else begin
        want = expected_q.pop_front();
        check_field("kind", 32'(want.kind), 32'(result_ch.payload.kind));
        check_field("byte_value", 32'(want.byte_value), 32'(result_ch.payload.byte_value));
        check_field("last", 32'(want.last), 32'(result_ch.payload.last));
        check_field("message_size", 32'(want.message_size),
                    32'(result_ch.payload.message_size));
        check_field("done_res", 32'(want.done_res), 32'(result_ch.payload.done_res));
        check_field("segmented", 32'(want.segmented), 32'(result_ch.payload.segmented));
        check_field("fc_id", 32'(want.fc_id), 32'(result_ch.payload.fc_id));
        check_field("fc_length", 32'(want.fc_length), 32'(result_ch.payload.fc_length));
      end
    end
  end

  task automatic test_single_frames();
    isotp_pkg::frame_t f;
    send_frame(make_frame(29'd0, 4'd1, {isotp_pkg::PCI_SF, 4'd0}));
    send_frame(make_frame(29'd0, 4'd8, {isotp_pkg::PCI_SF, 4'd1}));
    f = make_frame(29'd0, 4'd8, {isotp_pkg::PCI_SF, 4'd7});
    {f.byte1, f.byte2, f.byte3, f.byte4, f.byte5, f.byte6, f.byte7} = '1;
    send_frame(f);
    f = make_frame(29'd0, 4'd8, {isotp_pkg::PCI_SF, 4'd8});
    {f.byte1, f.byte2, f.byte3, f.byte4, f.byte5, f.byte6, f.byte7} = '0;
    send_frame(f);
    send_frame(make_frame(29'd0, 4'd3, {isotp_pkg::PCI_SF, 4'd15}));
  endtask

  task automatic test_ignored_frames();
    send_frame(make_frame(29'd0, 4'd0, {isotp_pkg::PCI_SF, 4'd5}));
    send_frame(make_frame(29'h1FFFFFFF, 4'd8, {isotp_pkg::PCI_SF, 4'd3}));
    send_frame(make_frame(29'd0, 4'd8, {PCI_FLOW, 4'hF}));
    send_frame(make_frame(29'd0, 4'd8, {PCI_MAX, 4'h0}));
    send_frame(make_frame(29'd1, 4'd8, {isotp_pkg::PCI_CONSEC, 4'd1}));
  endtask

  task automatic test_segmented();
    isotp_pkg::frame_t f;
    f = make_frame(29'd0, 4'd8, {isotp_pkg::PCI_FIRST, 4'd0});
    f.byte1 = 8'd20;
    send_frame(f);
    send_frame(make_frame(29'd0, 4'd8, {isotp_pkg::PCI_CONSEC, 4'd1}));
    send_frame(make_frame(29'd0, 4'd8, {isotp_pkg::PCI_CONSEC, 4'd2}));
    send_frame(make_frame(29'd0, 4'd2, {isotp_pkg::PCI_CONSEC, 4'd3}));
  endtask

  task automatic test_config_extremes();
    isotp_pkg::frame_t f;
    set_config(29'h1FFFFFFF, 1'b0, 12'd0);
    f = make_frame(29'h1FFFFFFF, 4'd8, {isotp_pkg::PCI_FIRST, 4'd0});
    f.byte1 = 8'd1;
    send_frame(f);
    f.byte1 = 8'd0;
    f.frame_len = 4'd1;
    send_frame(f);
    send_frame(make_frame(29'h1FFFFFFF, 4'd8, {isotp_pkg::PCI_CONSEC, 4'd1}));
    set_config(29'($urandom), 1'b1, 12'hFFF);
    f = make_frame(m_rx_id, 4'd8, {isotp_pkg::PCI_FIRST, 4'hF});
    f.byte1 = 8'hFF;
    send_frame(f);
    send_frame(make_frame(m_rx_id, 4'd8, {isotp_pkg::PCI_CONSEC, 4'd1}));
    set_config(29'd5, 1'b1, 12'd100);
    f = make_frame(29'd5, 4'd8, {isotp_pkg::PCI_FIRST, 4'd0});
    f.byte1 = 8'd101;
    send_frame(f);
    f.byte1 = 8'd100;
    send_frame(f);
    send_frame(make_frame(29'd5, 4'd8, {isotp_pkg::PCI_CONSEC, 4'd1}));
  endtask

  task automatic send_message();
    isotp_pkg::frame_t f;
    logic [11:0]       total;
    int                hi;
    int                ncf;
    if (m_max_size != 12'hFFF && $urandom_range(0, 9) == 0) begin
      total = 12'($urandom_range(m_max_size + 1, 4095));
    end else if ($urandom_range(0, 19) == 0) begin
      total = 12'($urandom_range(0, m_max_size));
    end else begin
      hi = (m_max_size < 60) ? m_max_size : 60;
      total = 12'($urandom_range((hi < 7) ? 0 : 7, hi));
    end
    if ($urandom_range(0, 5) == 0) send_frame(noise_frame());
    f = make_frame(m_rx_id, 4'($urandom_range(1, 8)), {isotp_pkg::PCI_FIRST, total[11:8]});
    f.byte1 = total[7:0];
    send_frame(f);
    ncf = (total < 6) ? 2 : ((total < 7) ? 1 : total / 7);
    if (ncf > 9) ncf = $urandom_range(2, 6);
    if ($urandom_range(0, 9) == 0) ncf = $urandom_range(0, ncf - 1);
    if ($urandom_range(0, 5) == 0) ncf++;
    for (int k = 0; k < ncf; k++) begin
      if ($urandom_range(0, 7) == 0) send_frame(noise_frame());
      send_frame(make_frame(m_rx_id, 4'($urandom_range(1, 8)),
                            {isotp_pkg::PCI_CONSEC, 4'(k + 1)}));
    end
  endtask

  task automatic test_random_traffic();
    int start;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: set_config(29'h1FFFFFFF, 1'b1, 12'hFFF);
        1: set_config(29'd0, 1'b0, 12'd100);
        2: set_config(29'($urandom), 1'b1, 12'($urandom_range(20, 300)));
        3: set_config(29'($urandom), 1'b0, 12'hFFF);
        4: set_config(29'($urandom), 1'($urandom), 12'd50);
        default: set_config(29'($urandom), 1'b1, 12'd6);
      endcase
      start = busy_frames;
      while (busy_frames - start < PHASE_FRAMES) send_message();
    end
  endtask

  initial begin
    int waited;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = isotp_pkg::CFG_RX_ID;
    cfg_data         = 29'd0;
    frame_ch.valid   = 1'b0;
    frame_ch.payload = '0;
    result_ch.ready  = 1'b0;
    m_rx_id          = 29'd0;
    m_pad            = 1'b1;
    m_max_size       = 12'hFFF;
    m_rcv_count      = 12'd0;
    m_total          = 12'd0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_single_frames();
    test_ignored_frames();
    test_segmented();
    test_config_extremes();
    test_random_traffic();

    frame_ch.valid <= 1'b0;
    waited = 0;
    while (expected_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_q.size() != 0) begin
      errors++;
      $display("%0t: %0d expected result beats never arrived", $time, expected_q.size());
    end
    repeat (20) @(posedge clk);

    $display("Sent %0d frames (%0d with results) across %0d register settings.",
             frames_sent, busy_frames, phases);
    $display("Checked %0d result beats, %0d messages reassembled.", results_seen, completions);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d result beats outstanding", expected_q.size());
    $display("Some tests failed");
    $finish;
  end

endmodule
